// ===== src/fasta_record_parser_defines.svh =====
// Assertion macros shared by the FASTA record parser modules.
// Depends on nothing; the using module must declare clk and rst_n.
`ifndef FASTA_RECORD_PARSER_DEFINES_SVH
`define FASTA_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define FRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FRP_ASSERT_IMP(lbl, ante, cons, msg)
`define FRP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/frp_pkg.sv =====
// Shared types, codes and byte classification for the FASTA record parser.
// Depends on nothing.
package frp_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int LEN_EXT_W   = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_DESC   = 3'd1;
  localparam logic [2:0] KIND_SEQ    = 3'd2;
  localparam logic [2:0] KIND_REC    = 3'd3;
  localparam logic [2:0] KIND_STREAM = 3'd4;
  localparam logic [2:0] KIND_ERR    = 3'd5;

  localparam logic [2:0] ERR_NO_START   = 3'd0;
  localparam logic [2:0] ERR_END_NAME   = 3'd1;
  localparam logic [2:0] ERR_END_DESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_BASE   = 3'd3;
  localparam logic [2:0] ERR_EMPTY_NAME = 3'd4;
  localparam logic [2:0] ERR_EMPTY_SEQ  = 3'd5;

  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  error_code;
    logic [31:0] sequence_length;
    logic        last;
  } frp_result_t;

  // Results produced by one byte, handed from the parser to the queue.
  typedef struct packed {
    logic [1:0]  n;
    frp_result_t r0;
    frp_result_t r1;
  } frp_push_t;

  function automatic frp_result_t frp_mk(logic [2:0] kind, logic [7:0] b,
                                         logic [2:0] err, logic [31:0] len,
                                         logic last);
    frp_result_t r;
    r.kind            = kind;
    r.out_byte        = b;
    r.error_code      = err;
    r.sequence_length = len;
    r.last            = last;
    return r;
  endfunction

  function automatic logic frp_is_ws(logic [7:0] b);
    return (b == CH_LF) || (b == CH_CR) || (b == CH_TAB) || (b == CH_SP);
  endfunction

  function automatic logic frp_is_base(logic [7:0] b);
    logic       alpha;
    logic [7:0] c;
    logic       hit;
    alpha = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    c     = b | 8'h20;
    case (c)
      8'h61, 8'h63, 8'h67, 8'h75, 8'h74, 8'h6E, 8'h72, 8'h79, 8'h6B,
      8'h6D, 8'h73, 8'h77, 8'h62, 8'h64, 8'h68, 8'h76, 8'h78: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return alpha && hit;
  endfunction

  // Saturates the base count to the 32-bit reported length.
  function automatic logic [31:0] frp_sat_len(logic [LENGTH_BITS-1:0] v);
    logic [LEN_EXT_W-1:0] ext;
    ext = LEN_EXT_W'(v);
    if (ext > LEN_EXT_W'(33'h0_FFFF_FFFF)) begin
      return '1;
    end
    return ext[31:0];
  endfunction

endpackage

// ===== src/frp_if.sv =====
// Channel interfaces for the FASTA record parser: byte input and result output.
// Depends on nothing.
interface frp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface frp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [2:0]  error_code;
  logic [31:0] sequence_length;
  logic        last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output sequence_length, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input sequence_length, input last, output ready);
endinterface

// ===== src/fasta_record_parser.sv =====
// FASTA record parser: one input byte per cycle while the result queue has room. Bytes
// are registered, classified against the parse state and pushed to a four-entry queue.
// Each queue entry is read out as a result; a closing end of input yields two beats.
// The queue's output, one beat per cycle while ready is high, bounds the result rate.
// Synchronous active-low reset returns to awaiting a record start with an empty queue.
module fasta_record_parser import frp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  frp_in_if.sink    in_bus,
  frp_out_if.source out_bus
);

  frp_push_t push;
  logic      room;

  frp_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .room   (room),
    .push   (push)
  );

  frp_result_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

// ===== src/frp_parse_core.sv =====
// Input register, parse state and per-byte classification logic.
// Depends on frp_pkg, frp_if and fasta_record_parser_defines.svh.
`include "fasta_record_parser_defines.svh"

module frp_parse_core import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  frp_in_if.sink      in_bus,
  input  logic        room,
  output frp_push_t   push
);

  typedef enum logic [2:0] {
    PH_AWAIT, PH_NAME, PH_DSKIP, PH_DESC, PH_SEQ, PH_HALT
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic                   name_seen_r, name_seen_nxt;
  logic [LENGTH_BITS-1:0] base_r, base_nxt;
  logic                   in_v_r;
  logic [7:0]             byte_r;
  logic                   eof_r;
  logic                   adv;
  logic                   ws;
  frp_push_t              calc;

  assign adv          = in_v_r && room;
  assign in_bus.ready = !in_v_r || room;
  assign ws           = frp_is_ws(byte_r);

  always_comb begin
    phase_nxt     = phase_r;
    name_seen_nxt = name_seen_r;
    base_nxt      = base_r;
    calc.n        = 2'd0;
    calc.r0       = frp_mk(KIND_NAME, 8'h00, ERR_NO_START, 32'd0, 1'b1);
    calc.r1       = frp_mk(KIND_STREAM, 8'h00, ERR_NO_START, 32'd0, 1'b1);
    case (phase_r)
      PH_AWAIT: begin
        if (eof_r) begin
          calc.n  = 2'd1;
          calc.r0 = frp_mk(KIND_STREAM, 8'h00, ERR_NO_START, 32'd0, 1'b1);
        end else if (ws) begin
        end else if (byte_r != CH_GT) begin
          calc.n    = 2'd1;
          calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_NO_START, 32'd0, 1'b1);
          phase_nxt = PH_HALT;
        end else begin
          name_seen_nxt = 1'b0;
          base_nxt      = '0;
          phase_nxt     = PH_NAME;
        end
      end
      PH_NAME: begin
        if (eof_r) begin
          calc.n    = 2'd1;
          calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_END_NAME, 32'd0, 1'b1);
          phase_nxt = PH_HALT;
        end else if (ws) begin
          phase_nxt = (byte_r == CH_LF) ? PH_SEQ : PH_DSKIP;
        end else begin
          name_seen_nxt = 1'b1;
          calc.n        = 2'd1;
          calc.r0       = frp_mk(KIND_NAME, byte_r, ERR_NO_START, 32'd0, 1'b1);
        end
      end
      PH_DSKIP, PH_DESC: begin
        if (eof_r) begin
          calc.n    = 2'd1;
          calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_END_DESC, 32'd0, 1'b1);
          phase_nxt = PH_HALT;
        end else if (byte_r == CH_LF) begin
          phase_nxt = PH_SEQ;
        end else if ((phase_r == PH_DSKIP) && (byte_r == CH_CR || byte_r == CH_TAB ||
                                               byte_r == CH_SP)) begin
        end else begin
          phase_nxt = PH_DESC;
          calc.n    = 2'd1;
          calc.r0   = frp_mk(KIND_DESC, byte_r, ERR_NO_START, 32'd0, 1'b1);
        end
      end
      PH_SEQ: begin
        if (eof_r || (byte_r == CH_GT)) begin
          calc.n = 2'd1;
          if (!name_seen_r) begin
            calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_EMPTY_NAME, 32'd0, 1'b1);
            phase_nxt = PH_HALT;
          end else if (base_r == '0) begin
            calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_EMPTY_SEQ, 32'd0, 1'b1);
            phase_nxt = PH_HALT;
          end else begin
            calc.r0       = frp_mk(KIND_REC, 8'h00, ERR_NO_START, frp_sat_len(base_r),
                                   !eof_r);
            name_seen_nxt = 1'b0;
            base_nxt      = '0;
            if (eof_r) begin
              calc.n    = 2'd2;
              phase_nxt = PH_AWAIT;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
        end else if (ws) begin
        end else if (!frp_is_base(byte_r)) begin
          calc.n    = 2'd1;
          calc.r0   = frp_mk(KIND_ERR, 8'h00, ERR_BAD_BASE, 32'd0, 1'b1);
          phase_nxt = PH_HALT;
        end else begin
          if (!(&base_r)) begin
            base_nxt = base_r + LENGTH_BITS'(1);
          end
          calc.n  = 2'd1;
          calc.r0 = frp_mk(KIND_SEQ, byte_r, ERR_NO_START, 32'd0, 1'b1);
        end
      end
      PH_HALT: begin
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_comb begin
    push   = calc;
    push.n = adv ? calc.n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_AWAIT;
      name_seen_r <= 1'b0;
      base_r      <= '0;
      in_v_r      <= 1'b0;
    end else begin
      if (adv) begin
        phase_r     <= phase_nxt;
        name_seen_r <= name_seen_nxt;
        base_r      <= base_nxt;
      end
      if (in_bus.ready) begin
        in_v_r <= in_bus.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      byte_r <= in_bus.data_byte;
      eof_r  <= in_bus.end_of_input;
    end
  end

  `FRP_ASSERT_IMP(a_halt_silent, phase_r == PH_HALT, push.n == 2'd0, "results after halt")
  `FRP_ASSERT_NXT(a_err_halts, push.n != 2'd0 && push.r0.kind == KIND_ERR,
                  phase_r == PH_HALT, "error did not halt the parser")
  `FRP_ASSERT_IMP(a_pair_last, push.n == 2'd2, push.r1.last && !push.r0.last,
                  "last flag misplaced in a two-result beat")
  `FRP_ASSERT_IMP(a_push_room, push.n != 2'd0, room, "push without queue room")

endmodule

// ===== src/frp_result_queue.sv =====
// Four-entry result queue; takes up to two results per cycle, emits one beat.
// Depends on frp_pkg, frp_if and fasta_record_parser_defines.svh.
`include "fasta_record_parser_defines.svh"

module frp_result_queue import frp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  frp_push_t   push,
  output logic        room,
  frp_out_if.source   out_bus
);

  frp_result_t mem_r [4];
  logic [1:0]  head_r, head_nxt;
  logic [1:0]  tail_r, tail_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;
  frp_result_t head_q;

  assign room   = cnt_r <= 3'd2;
  assign pop    = out_bus.valid && out_bus.ready;
  assign head_q = mem_r[head_r];

  assign out_bus.valid           = cnt_r != 3'd0;
  assign out_bus.kind            = head_q.kind;
  assign out_bus.out_byte        = head_q.out_byte;
  assign out_bus.error_code      = head_q.error_code;
  assign out_bus.sequence_length = head_q.sequence_length;
  assign out_bus.last            = head_q.last;

  always_comb begin
    cnt_nxt  = cnt_r + 3'(push.n) - 3'(pop);
    tail_nxt = tail_r + push.n;
    head_nxt = head_r + 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      head_r <= 2'd0;
      tail_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[tail_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[tail_r + 2'd1] <= push.r1;
    end
  end

  `FRP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= 3'd4, "queue count out of range")
  `FRP_ASSERT_IMP(a_no_overflow, push.n != 2'd0, cnt_r <= 3'd2, "queue overflow")
  `FRP_ASSERT_NXT(a_pop_count, pop && push.n == 2'd0, cnt_r == $past(cnt_r) - 3'd1,
                  "pop did not drain the queue")

endmodule

// ===== sim/tb_fasta_record_parser.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fasta_record_parser: byte beats in, tagged result beats out.
// Depends on frp_pkg and the frp_in_if / frp_out_if interfaces. A directed table is followed
// by random FASTA streams, checked against a parser model here but for pinned table rows.
module tb_fasta_record_parser import frp_pkg::*; ();

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_BEATS = 1500;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [7:0] IUPAC [0:16] = '{"a", "c", "g", "u", "t", "n", "r", "y", "k",
                                          "m", "s", "w", "b", "d", "h", "v", "x"};

  typedef enum logic [2:0] {P_AWAIT, P_NAME, P_DSKIP, P_DESC, P_SEQ, P_HALT} parse_phase_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        eof;
    logic        pinned;
    frp_result_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  frp_in_if  in_bus();
  frp_out_if out_bus();

  fasta_record_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  parse_phase_t           cur_phase;
  logic [31:0]            name_cnt;
  logic [LENGTH_BITS-1:0] base_cnt;
  frp_result_t            parsed_q[$];
  frp_result_t            pending_q[$];
  dir_row_t               dir_tab [0:24];

  int   beats_sent = 0;
  int   mismatches = 0;
  int   tx_idle    = 15;
  int   rx_idle    = 71;
  logic hold_req;
  logic hold_taken;
  int   hold_left;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic frp_result_t result_of(logic [2:0] kind, logic [7:0] b, logic [2:0] err,
                                            logic [31:0] len, logic last);
    frp_result_t r;
    r.kind            = kind;
    r.out_byte        = b;
    r.error_code      = err;
    r.sequence_length = len;
    r.last            = last;
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_LF) || (b == CH_CR) || (b == CH_TAB) || (b == CH_SP);
  endfunction

  function automatic logic is_iupac(logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    if (!(((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z")))) begin
      return 1'b0;
    end
    for (int i = 0; i < 17; i++) begin
      if (IUPAC[i] == low) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void halt_with(logic [2:0] code);
    parsed_q.push_back(result_of(KIND_ERR, 8'h00, code, 32'd0, 1'b1));
    cur_phase = P_HALT;
  endfunction

  function automatic void start_record();
    name_cnt  = '0;
    base_cnt  = '0;
    cur_phase = P_NAME;
  endfunction

  // Returns 1 when the record closes with an error instead of a record end.
  function automatic logic close_record(logic last);
    logic [63:0] wide;
    if (name_cnt == 0) begin
      halt_with(ERR_EMPTY_NAME);
      return 1'b1;
    end
    if (base_cnt == 0) begin
      halt_with(ERR_EMPTY_SEQ);
      return 1'b1;
    end
    wide = 64'(base_cnt);
    parsed_q.push_back(result_of(KIND_REC, 8'h00, ERR_NONE,
                                 (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0], last));
    return 1'b0;
  endfunction

  function automatic void parse_beat(logic [7:0] b, logic eof);
    parsed_q.delete();
    case (cur_phase)
      P_AWAIT: begin
        if (eof) begin
          parsed_q.push_back(result_of(KIND_STREAM, 8'h00, ERR_NONE, 32'd0, 1'b1));
        end else if (b == CH_GT) begin
          start_record();
        end else if (!is_blank(b)) begin
          halt_with(ERR_NO_START);
        end
      end
      P_NAME: begin
        if (eof) begin
          halt_with(ERR_END_NAME);
        end else if (is_blank(b)) begin
          cur_phase = (b == CH_LF) ? P_SEQ : P_DSKIP;
        end else begin
          if (name_cnt != '1) name_cnt++;
          parsed_q.push_back(result_of(KIND_NAME, b, ERR_NONE, 32'd0, 1'b1));
        end
      end
      P_DSKIP, P_DESC: begin
        if (eof) begin
          halt_with(ERR_END_DESC);
        end else if (b == CH_LF) begin
          cur_phase = P_SEQ;
        end else if (!((cur_phase == P_DSKIP) && is_blank(b))) begin
          cur_phase = P_DESC;
          parsed_q.push_back(result_of(KIND_DESC, b, ERR_NONE, 32'd0, 1'b1));
        end
      end
      P_SEQ: begin
        if (eof) begin
          if (!close_record(1'b0)) begin
            parsed_q.push_back(result_of(KIND_STREAM, 8'h00, ERR_NONE, 32'd0, 1'b1));
            cur_phase = P_AWAIT;
            name_cnt  = '0;
            base_cnt  = '0;
          end
        end else if (b == CH_GT) begin
          if (!close_record(1'b1)) start_record();
        end else if (!is_blank(b)) begin
          if (!is_iupac(b)) begin
            halt_with(ERR_BAD_BASE);
          end else begin
            if (base_cnt != '1) base_cnt++;
            parsed_q.push_back(result_of(KIND_SEQ, b, ERR_NONE, 32'd0, 1'b1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t pass_row(logic [7:0] b, logic eof = 1'b0);
    dir_row_t r;
    r.b      = b;
    r.eof    = eof;
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic dir_row_t pin_row(logic [7:0] b, logic eof, logic [2:0] kind,
                                       logic [7:0] ob, logic [2:0] err, logic [31:0] len);
    dir_row_t r;
    r.b      = b;
    r.eof    = eof;
    r.pinned = 1'b1;
    r.want   = result_of(kind, ob, err, len, 1'b1);
    return r;
  endfunction

  function automatic logic [7:0] blank_byte(logic with_lf);
    logic [7:0] b;
    case ($urandom_range(with_lf ? 0 : 1, 3))
      0:       b = CH_LF;
      1:       b = CH_CR;
      2:       b = CH_TAB;
      default: b = CH_SP;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (is_blank(b));
    return b;
  endfunction

  function automatic logic [7:0] desc_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] any_base();
    return IUPAC[$urandom_range(0, 16)] ^ (($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00);
  endfunction

  // Offers one beat after a random gap and records what the block owes for it.
  task automatic send_beat(input logic [7:0] b, input logic eof,
                           input logic pinned = 1'b0, input frp_result_t want = '0);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.end_of_input <= eof;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    parse_beat(b, eof);
    if (pinned) begin
      pending_q.push_back(want);
    end else begin
      foreach (parsed_q[i]) pending_q.push_back(parsed_q[i]);
    end
    beats_sent++;
  endtask

  task automatic send_close();
    if ($urandom_range(0, 1) != 0) begin
      send_beat(CH_GT, 1'b0);
    end else begin
      send_beat(8'($urandom), 1'b1);
    end
  endtask

  // One well-formed file: a few records with random content, then end of input.
  task automatic send_stream();
    int n;
    repeat ($urandom_range(0, 2)) send_beat(blank_byte(1'b1), 1'b0);
    repeat ($urandom_range(1, 4)) begin
      send_beat(CH_GT, 1'b0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      repeat (n) send_beat(name_byte(), 1'b0);
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 3)) send_beat(blank_byte(1'b0), 1'b0);
        repeat ($urandom_range(0, 10)) send_beat(desc_byte(), 1'b0);
      end
      send_beat(CH_LF, 1'b0);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(21, 120) : $urandom_range(1, 20);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_beat(blank_byte(1'b1), 1'b0);
        send_beat(any_base(), 1'b0);
      end
    end
    send_beat(8'($urandom), 1'b1);
    if ($urandom_range(0, 7) == 0) send_beat(8'($urandom), 1'b1);
  endtask

  // Any error halts the block for good, so a single broken record ends the run.
  task automatic send_fault();
    logic [2:0] code;
    logic [7:0] b;
    code = 3'($urandom_range(0, 5));
    case (code)
      ERR_NO_START: begin
        do b = 8'($urandom); while (is_blank(b) || (b == CH_GT));
        send_beat(b, 1'b0);
      end
      ERR_END_NAME: begin
        send_beat(CH_GT, 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(name_byte(), 1'b0);
        send_beat(8'($urandom), 1'b1);
      end
      ERR_END_DESC: begin
        send_beat(CH_GT, 1'b0);
        send_beat(name_byte(), 1'b0);
        send_beat(blank_byte(1'b0), 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(desc_byte(), 1'b0);
        send_beat(8'($urandom), 1'b1);
      end
      ERR_BAD_BASE: begin
        send_beat(CH_GT, 1'b0);
        send_beat(name_byte(), 1'b0);
        send_beat(CH_LF, 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(any_base(), 1'b0);
        do b = 8'($urandom); while (is_blank(b) || (b == CH_GT) || is_iupac(b));
        send_beat(b, 1'b0);
      end
      ERR_EMPTY_NAME: begin
        send_beat(CH_GT, 1'b0);
        if ($urandom_range(0, 1) != 0) send_beat(blank_byte(1'b0), 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(any_base(), 1'b0);
        send_close();
      end
      default: begin
        send_beat(CH_GT, 1'b0);
        send_beat(name_byte(), 1'b0);
        send_beat(CH_LF, 1'b0);
        if ($urandom_range(0, 1) != 0) send_beat(blank_byte(1'b1), 1'b0);
        send_close();
      end
    endcase
    repeat (4) send_beat(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    in_bus.valid        <= 1'b0;
    in_bus.data_byte    <= '0;
    in_bus.end_of_input <= 1'b0;
    hold_req            <= 1'b0;
    cur_phase = P_AWAIT;
    name_cnt  = '0;
    base_cnt  = '0;
    dir_tab = '{
      pin_row(8'hA5, 1'b1, KIND_STREAM, 8'h00, ERR_NONE, 32'd0),
      pass_row(CH_SP),
      pass_row(CH_LF),
      pass_row(CH_TAB),
      pass_row(CH_GT),
      pin_row(8'hFF, 1'b0, KIND_NAME, 8'hFF, ERR_NONE, 32'd0),
      pin_row(8'h00, 1'b0, KIND_NAME, 8'h00, ERR_NONE, 32'd0),
      pin_row(CH_GT, 1'b0, KIND_NAME, CH_GT, ERR_NONE, 32'd0),
      pass_row(CH_TAB),
      pass_row(CH_CR),
      pin_row(8'h80, 1'b0, KIND_DESC, 8'h80, ERR_NONE, 32'd0),
      pin_row(CH_CR, 1'b0, KIND_DESC, CH_CR, ERR_NONE, 32'd0),
      pass_row(CH_LF),
      pin_row("A", 1'b0, KIND_SEQ, "A", ERR_NONE, 32'd0),
      pin_row("c", 1'b0, KIND_SEQ, "c", ERR_NONE, 32'd0),
      pass_row(CH_LF),
      pin_row("x", 1'b0, KIND_SEQ, "x", ERR_NONE, 32'd0),
      pass_row(CH_SP),
      pin_row(CH_GT, 1'b0, KIND_REC, 8'h00, ERR_NONE, 32'd3),
      pin_row("q", 1'b0, KIND_NAME, "q", ERR_NONE, 32'd0),
      pass_row(CH_LF),
      pin_row("V", 1'b0, KIND_SEQ, "V", ERR_NONE, 32'd0),
      pass_row(CH_CR),
      pass_row(8'h7F, 1'b1),
      pin_row(CH_GT, 1'b1, KIND_STREAM, 8'h00, ERR_NONE, 32'd0)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].b, dir_tab[i].eof, dir_tab[i].pinned, dir_tab[i].want);
    end
    while (beats_sent < $size(dir_tab) + RANDOM_BEATS) begin
      if ((tx_idle == 15) && (beats_sent > RANDOM_BEATS / 3)) begin
        tx_idle = 71;
        rx_idle <= 15;
      end else if ((tx_idle == 71) && (beats_sent > 2 * RANDOM_BEATS / 3)) begin
        tx_idle = 0;
        rx_idle  <= 0;
        hold_req <= 1'b1;
      end
      send_stream();
    end
    send_fault();
    in_bus.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // The one long hold lets the result queue fill up so that the input stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_taken    <= 1'b0;
      hold_left     <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    frp_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: kind %0d", out_bus.kind);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (out_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_bus.kind);
          mismatches++;
        end
        if (out_bus.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_bus.out_byte);
          mismatches++;
        end
        if (out_bus.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_bus.error_code);
          mismatches++;
        end
        if (out_bus.sequence_length !== want.sequence_length) begin
          $error("sequence_length: expected %0d, got %0d", want.sequence_length,
                 out_bus.sequence_length);
          mismatches++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_bus.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/frp_pkg.sv
src/frp_if.sv
src/frp_parse_core.sv
src/frp_result_queue.sv
src/fasta_record_parser.sv
sim/tb_fasta_record_parser.sv
